FILE: design/segment_intersect_param_macros.svh
`ifndef SEGMENT_INTERSECT_PARAM_MACROS_SVH
`define SEGMENT_INTERSECT_PARAM_MACROS_SVH

// same-cycle implication, checked on clk, quiet during reset
`define SIP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment intersect assertion failed");

// next-cycle implication, checked on clk, quiet during reset
`define SIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment intersect assertion failed");

`endif

FILE: design/sip_pkg.sv
package sip_pkg;

    localparam int COORD_BITS  = 24;
    localparam int T_FRAC_BITS = 16;

    // widths of the intermediate values
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;
    localparam int REM_BITS   = CROSS_BITS + 1;
    localparam int T_BITS     = T_FRAC_BITS + 1;

endpackage

FILE: design/segment_intersect_param.sv
// stages: differences, products, cross terms, magnitudes, range compare, then the divide steps
// throughput: one item per cycle; one restoring divide step per stage sets the depth
// the whole pipeline holds while a result waits on out_stall
// reset: rst_n asynchronous, active low, clears every stage valid bit; data is not reset
module segment_intersect_param
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sip_pkg::COORD_BITS-1:0] ax0,
    input  logic signed [sip_pkg::COORD_BITS-1:0] ay0,
    input  logic signed [sip_pkg::COORD_BITS-1:0] ax1,
    input  logic signed [sip_pkg::COORD_BITS-1:0] ay1,
    input  logic signed [sip_pkg::COORD_BITS-1:0] bx0,
    input  logic signed [sip_pkg::COORD_BITS-1:0] by0,
    input  logic signed [sip_pkg::COORD_BITS-1:0] bx1,
    input  logic signed [sip_pkg::COORD_BITS-1:0] by1,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic        [sip_pkg::T_BITS-1:0]   param_t
);
    import sip_pkg::*;
    `include "segment_intersect_param_macros.svh"

    logic adv;

    // stage 1: differences and box test
    logic                        s1_v_reg;
    logic                        s1_box_reg;
    logic signed [DIFF_BITS-1:0] dax_reg, day_reg, dbx_reg, dby_reg, dabx_reg, daby_reg;
    logic                        box_next;
    logic                        xlo_ok, xhi_ok, ylo_ok, yhi_ok;

    // stage 2: products
    logic                        s2_v_reg;
    logic                        s2_box_reg;
    logic signed [PROD_BITS-1:0] pn1_reg, pn2_reg, pd1_reg, pd2_reg;

    // stage 3: cross terms
    logic                         s3_v_reg;
    logic                         s3_box_reg;
    logic signed [CROSS_BITS-1:0] num_reg, den_reg;

    // stage 4: magnitudes and sign checks
    logic                  s4_v_reg;
    logic                  s4_ok_reg;
    logic [CROSS_BITS-1:0] an_reg, ad_reg;
    logic                  ok4_next;
    logic [CROSS_BITS-1:0] an_next, ad_next;

    // divider stages, index 0 is the range compare
    logic [T_FRAC_BITS:0]  dv_reg;
    logic [T_FRAC_BITS:0]  dok_reg, dok_next;
    logic [REM_BITS-1:0]   rem_reg  [0:T_FRAC_BITS];
    logic [REM_BITS-1:0]   rem_next [0:T_FRAC_BITS];
    logic [CROSS_BITS-1:0] dd_reg   [0:T_FRAC_BITS];
    logic [T_BITS-1:0]     quo_reg  [0:T_FRAC_BITS];
    logic [T_BITS-1:0]     quo_next [0:T_FRAC_BITS];

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_comb
    begin
        xlo_ok = (ax0 < bx0) || (ax0 < bx1) || (ax1 < bx0) || (ax1 < bx1);
        xhi_ok = (ax0 > bx0) || (ax0 > bx1) || (ax1 > bx0) || (ax1 > bx1);
        ylo_ok = (ay0 < by0) || (ay0 < by1) || (ay1 < by0) || (ay1 < by1);
        yhi_ok = (ay0 > by0) || (ay0 > by1) || (ay1 > by0) || (ay1 > by1);
        box_next = xlo_ok && xhi_ok && ylo_ok && yhi_ok;
    end

    always_comb
    begin
        an_next  = num_reg[CROSS_BITS-1] ? CROSS_BITS'(-num_reg) : CROSS_BITS'(num_reg);
        ad_next  = den_reg[CROSS_BITS-1] ? CROSS_BITS'(-den_reg) : CROSS_BITS'(den_reg);
        ok4_next = s3_box_reg && (den_reg != '0) &&
                   !((num_reg != '0) && (num_reg[CROSS_BITS-1] != den_reg[CROSS_BITS-1]));
    end

    always_comb
    begin
        logic [REM_BITS-1:0] shifted;
        logic                ge;
        // range compare: t above one is no hit, t equal to one sets the top bit
        dok_next[0] = s4_ok_reg && (ad_reg >= an_reg);
        if (an_reg == ad_reg)
        begin
            rem_next[0] = '0;
            quo_next[0] = T_BITS'(1) << T_FRAC_BITS;
        end
        else
        begin
            rem_next[0] = REM_BITS'(an_reg);
            quo_next[0] = '0;
        end
        for (int k = 1; k <= T_FRAC_BITS; k++)
        begin
            shifted     = rem_reg[k-1] << 1;
            ge          = shifted >= REM_BITS'(dd_reg[k-1]);
            rem_next[k] = ge ? shifted - REM_BITS'(dd_reg[k-1]) : shifted;
            quo_next[k] = quo_reg[k-1] | (T_BITS'(ge) << (T_FRAC_BITS - k));
            dok_next[k] = dok_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            dv_reg   <= '0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            dv_reg   <= {dv_reg[T_FRAC_BITS-1:0], s4_v_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_box_reg <= box_next;
            dax_reg    <= DIFF_BITS'(ax0) - DIFF_BITS'(ax1);
            day_reg    <= DIFF_BITS'(ay0) - DIFF_BITS'(ay1);
            dbx_reg    <= DIFF_BITS'(bx0) - DIFF_BITS'(bx1);
            dby_reg    <= DIFF_BITS'(by0) - DIFF_BITS'(by1);
            dabx_reg   <= DIFF_BITS'(ax0) - DIFF_BITS'(bx0);
            daby_reg   <= DIFF_BITS'(ay0) - DIFF_BITS'(by0);

            s2_box_reg <= s1_box_reg;
            pn1_reg    <= dabx_reg * dby_reg;
            pn2_reg    <= daby_reg * dbx_reg;
            pd1_reg    <= dax_reg * dby_reg;
            pd2_reg    <= day_reg * dbx_reg;

            s3_box_reg <= s2_box_reg;
            num_reg    <= CROSS_BITS'(pn1_reg) - CROSS_BITS'(pn2_reg);
            den_reg    <= CROSS_BITS'(pd1_reg) - CROSS_BITS'(pd2_reg);

            s4_ok_reg  <= ok4_next;
            an_reg     <= an_next;
            ad_reg     <= ad_next;

            dok_reg    <= dok_next;
            dd_reg[0]  <= ad_reg;
            for (int k = 0; k <= T_FRAC_BITS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
            for (int k = 1; k <= T_FRAC_BITS; k++)
            begin
                dd_reg[k] <= dd_reg[k-1];
            end
        end
    end

    assign out_valid = dv_reg[T_FRAC_BITS];
    assign hit       = dok_reg[T_FRAC_BITS];
    assign param_t   = dok_reg[T_FRAC_BITS] ? quo_reg[T_FRAC_BITS] : '0;

    `SIP_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, s1_v_reg)
    `SIP_ASSERT_NOW(a_miss_zero, out_valid && !hit, param_t == '0)
    `SIP_ASSERT_NOW(a_t_range, out_valid && hit, param_t <= (T_BITS'(1) << T_FRAC_BITS))
    `SIP_ASSERT_NOW(a_rem_below, dv_reg[T_FRAC_BITS] && dok_reg[T_FRAC_BITS],
        rem_reg[T_FRAC_BITS] < REM_BITS'(dd_reg[T_FRAC_BITS]))

endmodule

FILE: tb/sv/segment_intersect_param_tb.sv
module segment_intersect_param_tb;

    localparam int CB          = sip_pkg::COORD_BITS;
    localparam int TB          = sip_pkg::T_BITS;
    localparam int WIDE_BITS   = sip_pkg::CROSS_BITS + sip_pkg::T_FRAC_BITS + 1;
    localparam int COORD_MAX   = (1 << (CB - 1)) - 1;
    localparam int COORD_MIN   = -(1 << (CB - 1));
    localparam int N_DIRECTED  = 15;
    localparam int N_RANDOM    = 950;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic signed [CB-1:0] ax0;
        logic signed [CB-1:0] ay0;
        logic signed [CB-1:0] ax1;
        logic signed [CB-1:0] ay1;
        logic signed [CB-1:0] bx0;
        logic signed [CB-1:0] by0;
        logic signed [CB-1:0] bx1;
        logic signed [CB-1:0] by1;
        logic                 typed;
        logic                 hit;
        logic [TB-1:0]        t;
    } seg_row_t;

    typedef struct packed {
        logic          hit;
        logic [TB-1:0] t;
    } cross_result_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic hit;
    logic [TB-1:0] param_t;

    seg_row_t live_row = '0;

    seg_row_t      segment_pairs_q [$];
    cross_result_t expected_cross_q [$];
    int            fail_count  = 0;
    int            cycle_count = 0;
    int            send_idx    = 0;
    int            burst_left  = 0;
    int            gap_left    = 0;
    int            hold_left   = 0;
    int            mode_left   = 0;
    int            stall_mode  = 0;
    int            rx_seen     = 0;
    bit            long_hold_done = 1'b0;

    // ax0 ay0 ax1 ay1 bx0 by0 bx1 by1 typed hit t
    seg_row_t directed_rows [N_DIRECTED] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0},
        '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
          COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1, 0, 0},
        '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
          COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1, 0, 0},
        '{-4096, -4096, 4096, 4096, -4096, 4096, 4096, -4096, 1, 1, 32768},
        // parallel, zero denominator
        '{0, 0, 8192, 8192, 0, 4096, 8192, 12288, 1, 0, 0},
        // boxes touching on an edge
        '{0, 0, 4096, 4096, 4096, 0, 8192, 4096, 1, 0, 0},
        // crossing exactly at the end of a
        '{-4096, 0, 0, 0, -4096, -4096, 4096, 4096, 1, 1, 65536},
        // crossing exactly at the start of a
        '{0, 0, -4096, 0, -4096, -4096, 4096, 4096, 1, 1, 0},
        '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
          COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 0, 0, 0},
        '{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
          COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 0, 0, 0},
        '{-8192, 0, 8192, 4096, -4096, 8192, -2048, -8192, 0, 0, 0},
        // collinear on a flat line, degenerate boxes
        '{0, 0, 8192, 0, 4096, 0, 12288, 0, 1, 0, 0},
        '{'h555555, 'haaaaaa, 'haaaaaa, 'h555555,
          'haaaaaa, 'haaaaaa, 'h555555, 'h555555, 0, 0, 0},
        '{0, 0, COORD_MAX, 1, 0, 1, COORD_MAX, 0, 0, 0, 0},
        // collinear diagonal, num and den both zero
        '{0, 0, 8192, 8192, 4096, 4096, 12288, 12288, 1, 0, 0}
    };

    segment_intersect_param i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ax0       (live_row.ax0),
        .ay0       (live_row.ay0),
        .ax1       (live_row.ax1),
        .ay1       (live_row.ay1),
        .bx0       (live_row.bx0),
        .by0       (live_row.by0),
        .bx1       (live_row.bx1),
        .by1       (live_row.by1),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .param_t   (param_t)
    );

    always #5 clk = ~clk;

    function automatic cross_result_t predict_cross(input seg_row_t r);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint bdy, bdx, num, den;
        logic [WIDE_BITS-1:0] an, ad;
        cross_result_t res;
        x1 = longint'($signed(r.ax0));
        y1 = longint'($signed(r.ay0));
        x2 = longint'($signed(r.ax1));
        y2 = longint'($signed(r.ay1));
        x3 = longint'($signed(r.bx0));
        y3 = longint'($signed(r.by0));
        x4 = longint'($signed(r.bx1));
        y4 = longint'($signed(r.by1));
        res = '0;
        if (!(((x1 < x2) ? x1 : x2) < ((x3 > x4) ? x3 : x4) &&
              ((x1 > x2) ? x1 : x2) > ((x3 < x4) ? x3 : x4) &&
              ((y1 < y2) ? y1 : y2) < ((y3 > y4) ? y3 : y4) &&
              ((y1 > y2) ? y1 : y2) > ((y3 < y4) ? y3 : y4)))
            return res;
        bdy = y3 - y4;
        bdx = x3 - x4;
        num = (x1 - x3) * bdy - (y1 - y3) * bdx;
        den = (x1 - x2) * bdy - (y1 - y2) * bdx;
        if (den == 0)
            return res;
        if (num != 0 && ((num < 0) != (den < 0)))
            return res;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        if (ad < an)
            return res;
        an = an << sip_pkg::T_FRAC_BITS;
        res.hit = 1'b1;
        res.t   = TB'(an / ad);
        return res;
    endfunction

    function automatic int jitter(input int s);
        return int'($urandom_range(0, 1 << (s + 1))) - (1 << s);
    endfunction

    function automatic logic signed [CB-1:0] extreme_coord();
        case ($urandom_range(0, 5))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return COORD_MIN + 1;
            3: return COORD_MAX - 1;
            4: return 0;
            default: return -1;
        endcase
    endfunction

    function automatic seg_row_t random_pair();
        seg_row_t r;
        int mode, s, js, cx, cy, vx, vy, wx, wy;
        r    = '0;
        mode = $urandom_range(0, 9);
        s    = $urandom_range(1, 21);
        js   = $urandom_range(0, s);
        cx   = jitter(22);
        cy   = jitter(22);
        vx   = jitter(s);
        vy   = jitter(s);
        wx   = jitter(s);
        wy   = jitter(s);
        case (mode)
            0, 1:
            begin
                r.ax0 = $urandom();
                r.ay0 = $urandom();
                r.ax1 = $urandom();
                r.ay1 = $urandom();
                r.bx0 = $urandom();
                r.by0 = $urandom();
                r.bx1 = $urandom();
                r.by1 = $urandom();
            end
            7:
            begin
                // b is a shifted copy of a
                r.ax0 = cx + vx;
                r.ay0 = cy + vy;
                r.ax1 = cx - vx;
                r.ay1 = cy - vy;
                js    = $urandom_range(0, 1) ? 0 : js;
                r.bx0 = r.ax0 + ((js == 0) ? 0 : jitter(js));
                r.by0 = r.ay0 + ((js == 0) ? 0 : jitter(js));
                r.bx1 = r.bx0 + (r.ax1 - r.ax0);
                r.by1 = r.by0 + (r.ay1 - r.ay0);
            end
            8:
            begin
                r.ax0 = cx + vx;
                r.ay0 = cy + vy;
                r.ax1 = cx - vx;
                r.ay1 = cy - vy;
                if ($urandom_range(0, 1))
                begin
                    // shared end point
                    r.bx0 = r.ax1;
                    r.by0 = r.ay1;
                    r.bx1 = cx + wx;
                    r.by1 = cy + wy;
                end
                else
                begin
                    // b starts on the right edge of a's box
                    r.bx0 = (r.ax0 > r.ax1) ? r.ax0 : r.ax1;
                    r.bx1 = r.bx0 + ((wx < 0) ? -wx : wx);
                    r.by0 = cy + wy;
                    r.by1 = cy - wy;
                end
            end
            9:
            begin
                r.ax0 = extreme_coord();
                r.ay0 = extreme_coord();
                r.ax1 = extreme_coord();
                r.ay1 = extreme_coord();
                r.bx0 = extreme_coord();
                r.by0 = extreme_coord();
                r.bx1 = extreme_coord();
                r.by1 = extreme_coord();
            end
            default:
            begin
                // both segments pass near a common centre
                r.ax0 = cx + vx;
                r.ay0 = cy + vy;
                r.ax1 = cx - vx + jitter(js);
                r.ay1 = cy - vy + jitter(js);
                r.bx0 = cx + wx;
                r.by0 = cy + wy;
                r.bx1 = cx - wx + jitter(js);
                r.by1 = cy - wy + jitter(js);
            end
        endcase
        return r;
    endfunction

    // item sender, bursts with gaps
    always @(posedge clk)
    begin
        logic nxt_valid;
        nxt_valid = in_valid;
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                nxt_valid = 1'b0;
            end
            else if (send_idx < segment_pairs_q.size())
            begin
                live_row <= segment_pairs_q[send_idx];
                send_idx++;
                nxt_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                nxt_valid = 1'b0;
        end
        in_valid <= nxt_valid;
    end

    // receiver stall pattern with one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                rx_seen++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!long_hold_done && rx_seen >= 200)
            begin
                long_hold_done = 1'b1;
                hold_left      = 150;
                out_stall     <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(10, 80);
                end
                mode_left--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // expectations on accepted items, checks on accepted results
    always @(posedge clk)
    begin
        cross_result_t exp_res;
        cross_result_t new_res;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (live_row.typed)
                begin
                    new_res.hit = live_row.hit;
                    new_res.t   = live_row.t;
                end
                else
                    new_res = predict_cross(live_row);
                expected_cross_q = {expected_cross_q, new_res};
            end
            if (out_valid && !out_stall)
            begin
                if (expected_cross_q.size() == 0)
                begin
                    $error("result with no item outstanding: hit %0d param_t %0d",
                           hit, param_t);
                    fail_count++;
                end
                else
                begin
                    exp_res = expected_cross_q.pop_front();
                    if (hit !== exp_res.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", exp_res.hit, hit);
                        fail_count++;
                    end
                    if (param_t !== exp_res.t)
                    begin
                        $error("param_t: expected %0d, actual %0d", exp_res.t, param_t);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < N_DIRECTED; i++)
            segment_pairs_q = {segment_pairs_q, directed_rows[i]};
        repeat (N_RANDOM)
            segment_pairs_q = {segment_pairs_q, random_pair()};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (send_idx < segment_pairs_q.size() || in_valid)
            @(posedge clk);
        while (expected_cross_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_cross_q.size() != 0)
        begin
            $error("%0d results outstanding at end", expected_cross_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/sip_pkg.sv
design/segment_intersect_param.sv
tb/sv/segment_intersect_param_tb.sv
